// ===== src/tpcc_pkg.sv =====
package tpcc_pkg;

  // Field widths fixed by the external interface
  localparam int REQ_W  = 3;
  localparam int ID_W   = 4;
  localparam int MASK_W = 8;
  localparam int SID_W  = 3;
  localparam int KIND_W = 2;
  localparam int ERR_W  = 2;
  localparam int AGE_W  = 16;
  localparam int TO_W   = 16;

  // Request types
  localparam logic [REQ_W-1:0] REQ_BEGIN    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PREPARED = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ABORT    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TIMEOUT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PREPARE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMMIT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROLLBACK = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR    = 2'd3;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_EMPTY   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EXISTS  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN = 2'd2;
  localparam logic [ERR_W-1:0] ERR_FOREIGN = 2'd3;

  localparam logic [TO_W-1:0]  TIMEOUT_RST = 16'd1000;
  localparam logic [AGE_W-1:0] AGE_MAX     = 16'hFFFF;

  // One table entry held in the slot memory
  typedef struct packed {
    logic [MASK_W-1:0] member;
    logic [MASK_W-1:0] voted;
    logic [AGE_W-1:0]  age;
  } entry_t;

  // One result without its last marker
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   tx;
    logic [MASK_W-1:0] parts;
    logic [ERR_W-1:0]  err;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic rd;
    logic exec;
    logic adv;
    logic flush;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_drop;
    logic in_tick;
    logic slot_open;
    logic sweep_end;
    logic ev_emit;
    logic can_emit;
    logic pend_valid;
    logic out_free;
  } stat_t;

endpackage

// ===== src/tpcc_ctrl.sv =====
module tpcc_ctrl
  import tpcc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_EV    = 6'b000100,
    S_SWEEP = 6'b001000,
    S_TEV   = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Sequence one request through read, evaluate and result hand-off, or a tick through sweep and flush
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.in_drop) begin
            state_nxt = S_IDLE;
          end else if (stat.in_tick) begin
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        if (!stat.ev_emit || stat.can_emit) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (stat.slot_open) begin
          cmd.rd    = 1'b1;
          state_nxt = S_TEV;
        end else if (stat.sweep_end) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      S_TEV: begin
        if (!stat.ev_emit || stat.can_emit) begin
          cmd.exec = 1'b1;
          if (stat.sweep_end) begin
            state_nxt = S_FLUSH;
          end else begin
            cmd.adv   = 1'b1;
            state_nxt = S_SWEEP;
          end
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/tpcc_dpath.sv =====
module tpcc_dpath
  import tpcc_pkg::*;
#(
  parameter int TX_SLOTS     = 16,
  parameter int MAX_SERVICES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [TO_W-1:0]    cfg_wdata,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [ID_W-1:0]    in_tx_id,
  input  logic [MASK_W-1:0]  in_service_mask,
  input  logic [SID_W-1:0]   in_service_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  out_kind,
  output logic [ID_W-1:0]    out_result_tx,
  output logic [MASK_W-1:0]  out_participants,
  output logic [ERR_W-1:0]   out_error_code,
  output logic               out_last,
  input  cmd_t               cmd,
  output stat_t              stat
);

  localparam int AW = $clog2(TX_SLOTS);
  localparam logic [MASK_W-1:0] SVC_BITS =
    (MAX_SERVICES >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << MAX_SERVICES) - 1);
  localparam logic [AW-1:0] IDX_LAST = AW'(TX_SLOTS - 1);

  logic [TO_W-1:0]   timeout_r;
  logic [REQ_W-1:0]  req_r;
  logic [ID_W-1:0]   tx_r;
  logic [MASK_W-1:0] smask_r;
  logic [SID_W-1:0]  sid_r;
  logic [AW-1:0]     idx_r;
  logic [TX_SLOTS-1:0] used_r, commit_r, abort_r;
  entry_t            mem [TX_SLOTS];
  entry_t            rdata_r;
  res_t              pend_r;
  logic              pend_valid_r;
  res_t              out_r;
  logic              out_last_r;
  logic              out_valid_r;

  logic              tick_r;
  logic              tx_bad;
  logic              cur_used, cur_commit, cur_abort;
  logic [MASK_W-1:0] sid_bit, voted_new;
  logic              foreign;
  logic [AGE_W-1:0]  age_inc;
  logic [TO_W-1:0]   lim;
  logic              ev_emit, flag_we, mem_we;
  logic              ev_used, ev_commit, ev_abort;
  entry_t            ev_entry;
  res_t              ev_res;
  logic              emit_now, load_direct, push_pend;

  // Timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // Capture the request and point the slot index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req_type;
      tx_r    <= in_tx_id;
      smask_r <= in_service_mask & SVC_BITS;
      sid_r   <= in_service_id;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= (in_req_type == REQ_TICK) ? '0 : AW'(in_tx_id);
    end else if (cmd.adv) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  assign tick_r     = (req_r == REQ_TICK);
  assign tx_bad     = 32'(tx_r) >= TX_SLOTS;
  assign cur_used   = used_r[idx_r];
  assign cur_commit = commit_r[idx_r];
  assign cur_abort  = abort_r[idx_r];

  // Slot memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[idx_r] <= ev_entry;
    end
    if (cmd.rd) begin
      rdata_r <= mem[idx_r];
    end
  end

  // Per-slot state flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      commit_r <= '0;
      abort_r  <= '0;
    end else if (cmd.exec && flag_we) begin
      used_r[idx_r]   <= ev_used;
      commit_r[idx_r] <= ev_commit;
      abort_r[idx_r]  <= ev_abort;
    end
  end

  assign sid_bit   = MASK_W'(1) << sid_r;
  assign voted_new = rdata_r.voted | sid_bit;
  assign foreign   = (32'(sid_r) >= MAX_SERVICES) || ((rdata_r.member & sid_bit) == '0);
  assign age_inc   = (rdata_r.age == AGE_MAX) ? rdata_r.age : rdata_r.age + 1'b1;
  assign lim       = (timeout_r == '0) ? TO_W'(1) : timeout_r;

  // Evaluate the request against the selected slot
  always_comb begin
    ev_emit      = 1'b0;
    flag_we      = 1'b0;
    mem_we       = 1'b0;
    ev_used      = cur_used;
    ev_commit    = cur_commit;
    ev_abort     = cur_abort;
    ev_entry     = rdata_r;
    ev_res.kind  = KIND_ERROR;
    ev_res.tx    = tick_r ? ID_W'(idx_r) : tx_r;
    ev_res.parts = '0;
    ev_res.err   = ERR_EMPTY;
    if (tick_r) begin
      // age an open slot and expire it when still unprepared
      mem_we       = 1'b1;
      ev_entry.age = age_inc;
      if (age_inc >= lim && rdata_r.voted != rdata_r.member) begin
        flag_we      = 1'b1;
        ev_abort     = 1'b1;
        ev_emit      = 1'b1;
        ev_res.kind  = KIND_ROLLBACK;
        ev_res.parts = rdata_r.member;
      end
    end else if (tx_bad) begin
      ev_emit    = 1'b1;
      ev_res.err = ERR_UNKNOWN;
    end else if (req_r == REQ_BEGIN) begin
      ev_emit = 1'b1;
      if (smask_r == '0) begin
        ev_res.err = ERR_EMPTY;
      end else if (cur_used) begin
        ev_res.err = ERR_EXISTS;
      end else begin
        flag_we        = 1'b1;
        ev_used        = 1'b1;
        ev_commit      = 1'b0;
        ev_abort       = 1'b0;
        mem_we         = 1'b1;
        ev_entry.member = smask_r;
        ev_entry.voted = '0;
        ev_entry.age   = '0;
        ev_res.kind    = KIND_PREPARE;
        ev_res.parts   = smask_r;
      end
    end else if (!cur_used) begin
      ev_emit    = 1'b1;
      ev_res.err = ERR_UNKNOWN;
    end else if (foreign) begin
      ev_emit    = 1'b1;
      ev_res.err = ERR_FOREIGN;
    end else if (req_r == REQ_PREPARED) begin
      mem_we         = 1'b1;
      ev_entry.voted = voted_new;
      if (voted_new == rdata_r.member && !cur_abort && !cur_commit) begin
        flag_we      = 1'b1;
        ev_commit    = 1'b1;
        ev_emit      = 1'b1;
        ev_res.kind  = KIND_COMMIT;
        ev_res.parts = rdata_r.member;
      end
    end else if (!cur_abort && !cur_commit) begin
      // abort or timeout vote rolls back once
      flag_we      = 1'b1;
      ev_abort     = 1'b1;
      ev_emit      = 1'b1;
      ev_res.kind  = KIND_ROLLBACK;
      ev_res.parts = rdata_r.member;
    end
  end

  assign emit_now    = cmd.exec && ev_emit;
  assign load_direct = emit_now && !tick_r;
  assign push_pend   = emit_now && tick_r && pend_valid_r;

  // Hold one sweep result back so the final one can carry last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.flush) begin
      pend_valid_r <= 1'b0;
    end else if (emit_now && tick_r) begin
      pend_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now && tick_r) begin
      pend_r <= ev_res;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_direct || push_pend || cmd.flush) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      out_r      <= ev_res;
      out_last_r <= 1'b1;
    end else if (push_pend) begin
      out_r      <= pend_r;
      out_last_r <= 1'b0;
    end else if (cmd.flush) begin
      out_r      <= pend_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_result_tx    = out_r.tx;
  assign out_participants = out_r.parts;
  assign out_error_code   = out_r.err;
  assign out_last         = out_last_r;

  // Status for the controller
  assign stat.in_drop    = in_req_type > REQ_TICK;
  assign stat.in_tick    = in_req_type == REQ_TICK;
  assign stat.slot_open  = cur_used && !cur_commit && !cur_abort;
  assign stat.sweep_end  = idx_r == IDX_LAST;
  assign stat.ev_emit    = ev_emit;
  assign stat.can_emit   = tick_r ? (!pend_valid_r || !out_valid_r) : !out_valid_r;
  assign stat.pend_valid = pend_valid_r;
  assign stat.out_free   = !out_valid_r;

endmodule

// ===== src/two_phase_commit_coordinator_core.sv =====
// Two-phase commit coordinator over a table of TX_SLOTS transactions.
// Input channel (in_valid/in_ready) takes one request: begin, prepared vote,
// abort vote, timeout vote or tick. Result channel (out_valid/out_ready)
// delivers prepare, commit, rollback and error results; out_last marks the
// final result of a request. cfg_we/cfg_wdata write the timeout in ticks.
// A begin or vote is accepted in S_IDLE, its slot is read in S_RD and its
// result is loaded into the output register from S_EV; the next request is
// accepted once the controller is back in S_IDLE.
// A tick walks the table through the slot memory read port, a closed slot
// per cycle; an open slot is read in S_SWEEP and evaluated in S_TEV, which
// waits while its result cannot be emitted. S_FLUSH releases the final
// result, if any, with last, and the next request is accepted after that.
// Types 5 to 7 are dropped in the accept cycle.
// Reset clears the valid, commit and abort flags of every slot at once and
// sets the timeout to 1000; there is no clearing pass.
// A stalled receiver holds the result register; the next request is still
// accepted, and processing waits only when a new result needs the register.
module two_phase_commit_coordinator_core
  import tpcc_pkg::*;
#(
  parameter int TX_SLOTS     = 16,
  parameter int MAX_SERVICES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [TO_W-1:0]    cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [ID_W-1:0]    in_tx_id,
  input  logic [MASK_W-1:0]  in_service_mask,
  input  logic [SID_W-1:0]   in_service_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  out_kind,
  output logic [ID_W-1:0]    out_result_tx,
  output logic [MASK_W-1:0]  out_participants,
  output logic [ERR_W-1:0]   out_error_code,
  output logic               out_last
);

  cmd_t  cmd;
  stat_t stat;

  tpcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tpcc_dpath #(
    .TX_SLOTS     (TX_SLOTS),
    .MAX_SERVICES (MAX_SERVICES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_req_type      (in_req_type),
    .in_tx_id         (in_tx_id),
    .in_service_mask  (in_service_mask),
    .in_service_id    (in_service_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_result_tx    (out_result_tx),
    .out_participants (out_participants),
    .out_error_code   (out_error_code),
    .out_last         (out_last),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

// ===== src/tpcc_checker.sv =====
module tpcc_checker
  import tpcc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [KIND_W-1:0]  out_kind,
  input logic [ID_W-1:0]    out_result_tx,
  input logic [MASK_W-1:0]  out_participants,
  input logic [ERR_W-1:0]   out_error_code,
  input logic               out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_result_tx) && $stable(out_participants) &&
      $stable(out_error_code) && $stable(out_last))
    else $error("result changed while stalled");

  // Error results carry no participants
  a_err_parts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |-> out_participants == '0)
    else $error("error result with participants");

  // Non-error results carry a zero error code and a nonempty participant set
  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_ERROR |-> out_error_code == ERR_EMPTY &&
      out_participants != '0)
    else $error("bad fields on a non-error result");

  // Only a tick gives several results, and those are rollbacks
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_PREPARE || out_kind == KIND_COMMIT ||
      out_kind == KIND_ERROR) |-> out_last)
    else $error("single-result request without last");

endmodule

bind two_phase_commit_coordinator_core tpcc_checker u_tpcc_checker (.*);

// ===== test/two_phase_commit_coordinator_core_checker.sv =====
module two_phase_commit_coordinator_core_checker
  import tpcc_pkg::*;
#(
  parameter int TX_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [TO_W-1:0]   cfg_wdata,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [ID_W-1:0]   in_tx_id,
  input  logic [MASK_W-1:0] in_service_mask,
  input  logic [SID_W-1:0]  in_service_id,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [KIND_W-1:0] out_kind,
  input  logic [ID_W-1:0]   out_result_tx,
  input  logic [MASK_W-1:0] out_participants,
  input  logic [ERR_W-1:0]  out_error_code,
  input  logic              out_last,
  output int unsigned       mismatch_count,
  output int unsigned       results_due
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   tx;
    logic [MASK_W-1:0] parts;
    logic [ERR_W-1:0]  err;
    logic              last;
  } coord_result_t;

  // Shadow copy of the transaction table and the timeout register
  bit                slot_open [TX_SLOTS];
  logic [MASK_W-1:0] slot_members [TX_SLOTS];
  logic [MASK_W-1:0] slot_votes [TX_SLOTS];
  bit                slot_committed [TX_SLOTS];
  bit                slot_aborted [TX_SLOTS];
  logic [AGE_W-1:0]  slot_age [TX_SLOTS];
  logic [TO_W-1:0]   timeout_cfg = TIMEOUT_RST;

  coord_result_t     due_results [$];
  coord_result_t     oldest;
  int unsigned       error_total = 0;

  function automatic coord_result_t make_result(input logic [KIND_W-1:0] kind,
                                                input logic [ID_W-1:0] tx,
                                                input logic [MASK_W-1:0] parts,
                                                input logic [ERR_W-1:0] err);
    coord_result_t r;
    r.kind  = kind;
    r.tx    = tx;
    r.parts = parts;
    r.err   = err;
    r.last  = 1'b0;
    return r;
  endfunction

  // Apply one request to the shadow table and queue the results it causes
  task automatic predict_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] tx,
                                 input logic [MASK_W-1:0] smask,
                                 input logic [SID_W-1:0] sid);
    coord_result_t    batch [$];
    logic [AGE_W-1:0] expiry;
    int               s;
    expiry = (timeout_cfg == '0) ? AGE_W'(1) : timeout_cfg;
    if (req > REQ_TICK) begin
      return;
    end
    if (req == REQ_TICK) begin
      // Age open transactions and expire the unprepared ones in slot order
      for (s = 0; s < TX_SLOTS; s++) begin
        if (slot_open[s] && !slot_committed[s] && !slot_aborted[s]) begin
          if (slot_age[s] != AGE_MAX) slot_age[s]++;
          if (slot_age[s] >= expiry && slot_votes[s] != slot_members[s]) begin
            slot_aborted[s] = 1'b1;
            batch = {batch, make_result(KIND_ROLLBACK, ID_W'(s), slot_members[s], '0)};
          end
        end
      end
    end else if (int'(tx) >= TX_SLOTS) begin
      batch = {batch, make_result(KIND_ERROR, tx, '0, ERR_UNKNOWN)};
    end else if (req == REQ_BEGIN) begin
      if (smask == '0) begin
        batch = {batch, make_result(KIND_ERROR, tx, '0, ERR_EMPTY)};
      end else if (slot_open[tx]) begin
        batch = {batch, make_result(KIND_ERROR, tx, '0, ERR_EXISTS)};
      end else begin
        slot_open[tx]      = 1'b1;
        slot_members[tx]   = smask;
        slot_votes[tx]     = '0;
        slot_committed[tx] = 1'b0;
        slot_aborted[tx]   = 1'b0;
        slot_age[tx]       = '0;
        batch = {batch, make_result(KIND_PREPARE, tx, smask, '0)};
      end
    end else if (!slot_open[tx]) begin
      batch = {batch, make_result(KIND_ERROR, tx, '0, ERR_UNKNOWN)};
    end else if (!slot_members[tx][sid]) begin
      batch = {batch, make_result(KIND_ERROR, tx, '0, ERR_FOREIGN)};
    end else if (req == REQ_PREPARED) begin
      // Record the vote; commit once, and never after a rollback
      slot_votes[tx][sid] = 1'b1;
      if (slot_votes[tx] == slot_members[tx] && !slot_aborted[tx] && !slot_committed[tx]) begin
        slot_committed[tx] = 1'b1;
        batch = {batch, make_result(KIND_COMMIT, tx, slot_members[tx], '0)};
      end
    end else if (!slot_aborted[tx] && !slot_committed[tx]) begin
      slot_aborted[tx] = 1'b1;
      batch = {batch, make_result(KIND_ROLLBACK, tx, slot_members[tx], '0)};
    end
    if (batch.size() != 0) begin
      batch[batch.size() - 1].last = 1'b1;
      due_results = {due_results, batch};
    end
  endtask

  task automatic compare_field(input string field, input logic [MASK_W-1:0] want,
                               input logic [MASK_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      error_total++;
    end
  endtask

  // Track config writes and requests, then check each delivered result
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (slot_open[i]) begin
        slot_open[i]      = 1'b0;
        slot_members[i]   = '0;
        slot_votes[i]     = '0;
        slot_committed[i] = 1'b0;
        slot_aborted[i]   = 1'b0;
        slot_age[i]       = '0;
      end
      timeout_cfg = TIMEOUT_RST;
      due_results.delete();
    end else begin
      if (cfg_we) timeout_cfg = cfg_wdata;
      if (in_valid && in_ready) begin
        predict_request(in_req_type, in_tx_id, in_service_mask, in_service_id);
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d tx %0d", out_kind, out_result_tx);
          error_total++;
        end else begin
          oldest = due_results.pop_front();
          compare_field("out_kind", oldest.kind, out_kind);
          compare_field("out_result_tx", oldest.tx, out_result_tx);
          compare_field("out_participants", oldest.parts, out_participants);
          compare_field("out_error_code", oldest.err, out_error_code);
          compare_field("out_last", oldest.last, out_last);
        end
      end
    end
    results_due    <= due_results.size();
    mismatch_count <= error_total;
  end

endmodule

// ===== test/two_phase_commit_coordinator_core_test.sv =====
module two_phase_commit_coordinator_core_test;
  import tpcc_pkg::*;

  localparam int TX_SLOTS     = 16;
  localparam int MAX_SERVICES = 8;
  localparam int CYCLE_LIMIT  = 600000;
  // Long enough for a tick to walk the whole table, plus margin
  localparam int DRAIN_CYCLES = 2 * TX_SLOTS + 8;
  localparam int PHASE_ITEMS  = 44;

  // Request types the block drops without a result
  localparam logic [REQ_W-1:0] REQ_SPARE_LO  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_MID = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI  = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [TO_W-1:0]   cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic [REQ_W-1:0]  in_req_type = '0;
  logic [ID_W-1:0]   in_tx_id = '0;
  logic [MASK_W-1:0] in_service_mask = '0;
  logic [SID_W-1:0]  in_service_id = '0;
  logic              out_ready = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [ID_W-1:0]   out_result_tx;
  logic [MASK_W-1:0] out_participants;
  logic [ERR_W-1:0]  out_error_code;
  logic              out_last;

  int unsigned       mismatch_count;
  int unsigned       results_due;
  int unsigned       cycle_count = 0;
  int unsigned       counted_requests = 0;
  int                burst_left = 0;
  int unsigned       rx_mode = 0;
  int unsigned       rx_mode_left = 0;

  // What the stimulus knows of each slot, used only to steer votes
  bit                slot_taken [TX_SLOTS];
  bit [MASK_W-1:0]   slot_roster [TX_SLOTS];
  bit [MASK_W-1:0]   slot_ballot [TX_SLOTS];

  two_phase_commit_coordinator_core #(
    .TX_SLOTS    (TX_SLOTS),
    .MAX_SERVICES(MAX_SERVICES)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_tx_id        (in_tx_id),
    .in_service_mask (in_service_mask),
    .in_service_id   (in_service_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_result_tx   (out_result_tx),
    .out_participants(out_participants),
    .out_error_code  (out_error_code),
    .out_last        (out_last)
  );

  two_phase_commit_coordinator_core_checker #(
    .TX_SLOTS(TX_SLOTS)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_tx_id        (in_tx_id),
    .in_service_mask (in_service_mask),
    .in_service_id   (in_service_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_result_tx   (out_result_tx),
    .out_participants(out_participants),
    .out_error_code  (out_error_code),
    .out_last        (out_last),
    .mismatch_count  (mismatch_count),
    .results_due     (results_due)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("two_phase_commit_coordinator_core_test failed");
      $finish;
    end
  end

  // Receiver: switch between always ready, coin-flip and long stalls
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 2);
      rx_mode_left <= $urandom_range(20, 80);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [SID_W-1:0] pick_bit(input logic [MASK_W-1:0] m);
    int start;
    int k;
    start = $urandom_range(0, MASK_W - 1);
    for (k = 0; k < MASK_W; k++) begin
      if (m[(start + k) % MASK_W]) return SID_W'((start + k) % MASK_W);
    end
    return SID_W'(start);
  endfunction

  // Present one request, holding it until accepted; bursts with random gaps
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] tx,
                              input logic [MASK_W-1:0] smask,
                              input logic [SID_W-1:0] sid);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_tx_id        <= tx;
    in_service_mask <= smask;
    in_service_id   <= sid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req <= REQ_TICK) counted_requests++;
    if (req == REQ_BEGIN && smask != '0 && !slot_taken[tx]) begin
      slot_taken[tx]  = 1'b1;
      slot_roster[tx] = smask;
      slot_ballot[tx] = '0;
    end else if (req == REQ_PREPARED && slot_taken[tx] && slot_roster[tx][sid]) begin
      slot_ballot[tx][sid] = 1'b1;
    end
  endtask

  // Drop valid and wait until every result is out and a tick could have finished
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TO_W-1:0] ticks);
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random request, mostly aimed at the slots of the current phase
  task automatic random_request(input int base_slot, input int span);
    logic [ID_W-1:0]   tx;
    logic [SID_W-1:0]  sid;
    logic [MASK_W-1:0] fill;
    logic [MASK_W-1:0] missing;
    int                pick;
    int                k;
    int                start;
    tx   = ID_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, TX_SLOTS - 1)
                                              : base_slot + $urandom_range(0, span - 1));
    fill = MASK_W'($urandom_range(0, 255));
    sid  = SID_W'($urandom_range(0, MAX_SERVICES - 1));
    pick = $urandom_range(0, 99);
    missing = slot_roster[tx] & ~slot_ballot[tx];
    if (pick < 45) begin
      // Prepared vote, usually from a member that has not voted yet
      if (slot_taken[tx]) begin
        sid = (missing != '0 && $urandom_range(0, 4) != 0) ? pick_bit(missing)
                                                           : pick_bit(slot_roster[tx]);
      end
      send_request(REQ_PREPARED, tx, fill, sid);
    end else if (pick < 60) begin
      send_request(REQ_TICK, tx, fill, sid);
    end else if (pick < 72) begin
      if (slot_taken[tx]) sid = pick_bit(slot_roster[tx]);
      send_request((pick < 66) ? REQ_ABORT : REQ_TIMEOUT, tx, fill, sid);
    end else if (pick < 78) begin
      // Vote from a participant outside the set
      if (slot_taken[tx] && slot_roster[tx] != '1) sid = pick_bit(~slot_roster[tx]);
      send_request(REQ_W'($urandom_range(REQ_PREPARED, REQ_TIMEOUT)), tx, fill, sid);
    end else if (pick < 84) begin
      // Begin that can only fail: id in use or empty set
      send_request(REQ_BEGIN, tx, slot_taken[tx] ? fill : '0, sid);
    end else if (pick < 90) begin
      send_request(REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), tx, fill, sid);
    end else begin
      // Vote on a slot nobody has begun yet
      start = $urandom_range(0, TX_SLOTS - 1);
      for (k = 0; k < TX_SLOTS; k++) begin
        if (!slot_taken[(start + k) % TX_SLOTS]) tx = ID_W'((start + k) % TX_SLOTS);
      end
      send_request(REQ_W'($urandom_range(REQ_PREPARED, REQ_TIMEOUT)), tx, fill, sid);
    end
  endtask

  // Set a timeout, open a group of fresh slots and drive random traffic at them
  task automatic run_phase(input logic [TO_W-1:0] ticks, input int base_slot, input int span);
    int unsigned       goal;
    logic [MASK_W-1:0] roster;
    int                i;
    settle();
    write_timeout(ticks);
    goal = counted_requests + PHASE_ITEMS;
    for (i = 0; i < span; i++) begin
      case ($urandom_range(0, 7))
        0: roster = 8'h01;
        1: roster = 8'h80;
        2: roster = 8'hFF;
        default: roster = MASK_W'($urandom_range(1, 255));
      endcase
      send_request(REQ_BEGIN, ID_W'(base_slot + i), roster,
                   SID_W'($urandom_range(0, MAX_SERVICES - 1)));
    end
    while (counted_requests < goal) random_request(base_slot, span);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table tick and dropped request types
    send_request(REQ_TICK, 4'd0, 8'h00, 3'd0);
    send_request(REQ_SPARE_LO, 4'd5, 8'h55, 3'd5);
    send_request(REQ_SPARE_MID, 4'd10, 8'hAA, 3'd2);
    send_request(REQ_SPARE_HI, 4'd15, 8'hFF, 3'd7);
    // Begin with no participants, and votes on slots never begun
    send_request(REQ_BEGIN, 4'd0, 8'h00, 3'd0);
    send_request(REQ_PREPARED, 4'd10, 8'h00, 3'd1);
    send_request(REQ_ABORT, 4'd9, 8'hFF, 3'd7);
    send_request(REQ_TIMEOUT, 4'd8, 8'h0F, 3'd3);
    // Commit path, foreign vote, repeat commit, abort after commit
    send_request(REQ_BEGIN, 4'd14, 8'h81, 3'd0);
    send_request(REQ_BEGIN, 4'd14, 8'h01, 3'd0);
    send_request(REQ_PREPARED, 4'd14, 8'h00, 3'd0);
    send_request(REQ_PREPARED, 4'd14, 8'h00, 3'd3);
    send_request(REQ_PREPARED, 4'd14, 8'h00, 3'd7);
    send_request(REQ_PREPARED, 4'd14, 8'h00, 3'd7);
    send_request(REQ_ABORT, 4'd14, 8'h00, 3'd0);
    // Abort, second rollback suppressed, vote recorded after rollback
    send_request(REQ_BEGIN, 4'd15, 8'hFF, 3'd7);
    send_request(REQ_ABORT, 4'd15, 8'h00, 3'd7);
    send_request(REQ_TIMEOUT, 4'd15, 8'h00, 3'd0);
    send_request(REQ_PREPARED, 4'd15, 8'h00, 3'd5);
    send_request(REQ_BEGIN, 4'd13, 8'h7E, 3'd0);
    send_request(REQ_TIMEOUT, 4'd13, 8'h00, 3'd1);
    // Zero timeout behaves as one: a single tick expires both open slots
    settle();
    write_timeout(16'd0);
    send_request(REQ_BEGIN, 4'd12, 8'h0F, 3'd0);
    send_request(REQ_BEGIN, 4'd11, 8'h10, 3'd0);
    send_request(REQ_TICK, 4'd3, 8'h00, 3'd0);

    run_phase(16'hFFFF, 0, 3);
    run_phase(16'd1, 3, 2);
    run_phase(16'd2, 5, 2);
    run_phase(TO_W'($urandom_range(3, 12)), 7, 2);
    run_phase(16'd0, 9, 2);
    settle();

    if (mismatch_count == 0) begin
      $display("two_phase_commit_coordinator_core_test passed");
    end else begin
      $display("two_phase_commit_coordinator_core_test failed");
    end
    $finish;
  end

endmodule
